// ----- src/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, constants and field helpers for the pixel format converter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned NUM_CHAN     = 3;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned MAX_W        = 16;
  localparam int unsigned PIX_W        = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned QUO_W        = 8;
  localparam int unsigned SCALED_W     = MAX_W + QUO_W;
  localparam int unsigned BPP_W        = 6;
  localparam int unsigned DEPTH_W      = 6;
  localparam int unsigned SHIFTS_W     = SHIFT_W * NUM_CHAN;
  localparam int unsigned MAXES_W      = MAX_W * NUM_CHAN;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = MAXES_W;
  localparam int unsigned COUNT_W      = 3;

  // compact pixel rule: zrle true colour at 32 bpp with depth 24 or less
  localparam logic [BPP_W-1:0]   COMPACT_BPP   = 6'd32;
  localparam logic [DEPTH_W-1:0] COMPACT_DEPTH = 6'd24;

  localparam logic [BPP_W-1:0]    RST_BPP    = 6'd32;
  localparam logic [DEPTH_W-1:0]  RST_DEPTH  = 6'd24;
  localparam logic [SHIFTS_W-1:0] RST_SHIFTS = 15'd16640;
  localparam logic [MAXES_W-1:0]  RST_MAXES  = 48'd1095233372415;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_BPP     = 3'd0,
    CFG_IN_DEPTH   = 3'd1,
    CFG_IN_ZRLE    = 3'd2,
    CFG_IN_SHIFTS  = 3'd3,
    CFG_IN_MAXES   = 3'd4,
    CFG_OUT_SHIFTS = 3'd5,
    CFG_OUT_MAXES  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [BPP_W-1:0]    in_bpp;
    logic [DEPTH_W-1:0]  in_depth;
    logic                in_zrle;
    logic [SHIFTS_W-1:0] in_shifts;
    logic [MAXES_W-1:0]  in_maxes;
    logic [SHIFTS_W-1:0] out_shifts;
    logic [MAXES_W-1:0]  out_maxes;
  } cfg_t;

  // one gathered pixel, or a buffer that ended mid-pixel
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             overflow;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_wr_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_DIV,
    CV_DONE
  } cv_state_t;

  // red sits in the highest field
  function automatic logic [SHIFT_W-1:0] field_shift(logic [SHIFTS_W-1:0] shifts,
                                                     int unsigned chan);
    return shifts[SHIFT_W*(NUM_CHAN-1-chan) +: SHIFT_W];
  endfunction

  function automatic logic [MAX_W-1:0] field_max(logic [MAXES_W-1:0] maxes,
                                                 int unsigned chan);
    return maxes[MAX_W*(NUM_CHAN-1-chan) +: MAX_W];
  endfunction

  // bytes per input pixel, clamped to 1..4
  function automatic logic [COUNT_W-1:0] pixel_size(cfg_t cfg);
    logic [COUNT_W-1:0] n;
    n = cfg.in_bpp[BPP_W-1:3];
    if (cfg.in_zrle && cfg.in_bpp == COMPACT_BPP && cfg.in_depth <= COMPACT_DEPTH) begin
      return 3'd3;
    end
    if (n == 3'd0) begin
      return 3'd1;
    end
    if (n > 3'd4) begin
      return 3'd4;
    end
    return n;
  endfunction

endpackage

// ----- src/pfc_if.sv -----
// ----------------------------------------------------------------------------
// pfc channel interfaces
// Valid/ready channels for input bytes, converted pixels and register writes.
// ----------------------------------------------------------------------------
interface pfc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfc_pkg::BYTE_W-1:0]  data_byte;
  logic                        last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pfc_out_if;
  logic                       valid;
  logic                       ready;
  logic [pfc_pkg::PIX_W-1:0]  out_pixel;
  logic                       overflow;

  modport source (output valid, output out_pixel, output overflow, input ready);
  modport sink   (input valid, input out_pixel, input overflow, output ready);
endinterface

interface pfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::CFG_IDX_W-1:0]   index;
  logic [pfc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/pfc_regs.sv -----
// ----------------------------------------------------------------------------
// pfc_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module pfc_regs (
  input  logic            clk,
  input  logic            rst,
  pfc_cfg_if.sink         cfg_ch,
  output pfc_pkg::cfg_t   cfg
);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_bpp     <= pfc_pkg::RST_BPP;
      cfg.in_depth   <= pfc_pkg::RST_DEPTH;
      cfg.in_zrle    <= 1'b0;
      cfg.in_shifts  <= pfc_pkg::RST_SHIFTS;
      cfg.in_maxes   <= pfc_pkg::RST_MAXES;
      cfg.out_shifts <= pfc_pkg::RST_SHIFTS;
      cfg.out_maxes  <= pfc_pkg::RST_MAXES;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (pfc_pkg::cfg_idx_t'(cfg_ch.index))
        pfc_pkg::CFG_IN_BPP:     cfg.in_bpp     <= cfg_ch.data[pfc_pkg::BPP_W-1:0];
        pfc_pkg::CFG_IN_DEPTH:   cfg.in_depth   <= cfg_ch.data[pfc_pkg::DEPTH_W-1:0];
        pfc_pkg::CFG_IN_ZRLE:    cfg.in_zrle    <= cfg_ch.data[0];
        pfc_pkg::CFG_IN_SHIFTS:  cfg.in_shifts  <= cfg_ch.data[pfc_pkg::SHIFTS_W-1:0];
        pfc_pkg::CFG_IN_MAXES:   cfg.in_maxes   <= cfg_ch.data[pfc_pkg::MAXES_W-1:0];
        pfc_pkg::CFG_OUT_SHIFTS: cfg.out_shifts <= cfg_ch.data[pfc_pkg::SHIFTS_W-1:0];
        pfc_pkg::CFG_OUT_MAXES:  cfg.out_maxes  <= cfg_ch.data[pfc_pkg::MAXES_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/pfc_gather.sv -----
// ----------------------------------------------------------------------------
// pfc_gather
// Front end: gathers bytes big-endian into pixels and flags short buffers.
// ----------------------------------------------------------------------------
module pfc_gather (
  input  logic            clk,
  input  logic            rst,
  input  pfc_pkg::cfg_t   cfg,
  pfc_in_if.sink          in_ch,
  input  logic            q_full,
  output pfc_pkg::q_wr_t  q_wr
);

  logic [pfc_pkg::PIX_W-1:0]   acc;
  logic [pfc_pkg::PIX_W-1:0]   acc_next;
  logic [pfc_pkg::COUNT_W-1:0] count;
  logic [pfc_pkg::COUNT_W-1:0] count_next;
  logic                        accept;
  logic                        complete;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    acc_next   = {acc[pfc_pkg::PIX_W-pfc_pkg::BYTE_W-1:0], in_ch.data_byte};
    count_next = count + 3'd1;
    // a size change while mid-pixel takes effect at once
    complete   = count_next >= pfc_pkg::pixel_size(cfg);
    q_wr.valid         = accept && (complete || in_ch.last_byte);
    q_wr.item.pixel    = complete ? acc_next : '0;
    q_wr.item.overflow = !complete;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      count <= '0;
    end else if (accept) begin
      if (complete || in_ch.last_byte) begin
        acc   <= '0;
        count <= '0;
      end else begin
        acc   <= acc_next;
        count <= count_next;
      end
    end
  end

endmodule

// ----- src/pfc_queue.sv -----
// ----------------------------------------------------------------------------
// pfc_queue
// Short first-in first-out queue between the gatherer and the converter.
// ----------------------------------------------------------------------------
module pfc_queue #(
  parameter  int unsigned DEPTH = 2,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  pfc_pkg::q_wr_t    q_wr,
  input  logic              pop,
  output pfc_pkg::q_item_t  head,
  output logic              full,
  output logic              empty,
  output logic [CNT_W-1:0]  count
);

  pfc_pkg::q_item_t  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_wr.valid) begin
      mem[wr_ptr] <= q_wr.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({q_wr.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/pfc_convert.sv -----
// ----------------------------------------------------------------------------
// pfc_convert
// Back end: scales each channel with a restoring divider, packs the result.
// ----------------------------------------------------------------------------
module pfc_convert (
  input  logic              clk,
  input  logic              rst,
  input  pfc_pkg::cfg_t     cfg,
  input  pfc_pkg::q_item_t  head,
  input  logic              q_empty,
  output logic              pop,
  pfc_out_if.source         out_ch
);

  localparam int unsigned NC   = pfc_pkg::NUM_CHAN;
  localparam int unsigned MW   = pfc_pkg::MAX_W;
  localparam int unsigned QW   = pfc_pkg::QUO_W;
  localparam int unsigned PW   = pfc_pkg::PIX_W;
  localparam int unsigned STEP_W = $clog2(QW);

  pfc_pkg::cv_state_t  state;
  pfc_pkg::cv_state_t  state_next;
  logic                load_out;
  logic [STEP_W-1:0]   step;
  logic                ovf;

  logic [MW-1:0]                 rem     [NC];
  logic [QW-1:0]                 num_lo  [NC];
  logic [QW-1:0]                 quo     [NC];
  logic [MW-1:0]                 dvs     [NC];
  logic [MW-1:0]                 imax    [NC];
  logic [pfc_pkg::SCALED_W-1:0]  scaled  [NC];
  logic [MW:0]                   shifted [NC];
  logic                          ge      [NC];
  logic [MW:0]                   diff    [NC];
  logic [PW-1:0]                 pix_sh  [NC];
  logic [MW-1:0]                 masked  [NC];
  logic [PW-1:0]                 result;

  logic              out_valid;
  logic [PW-1:0]     out_pixel;
  logic              out_ovf;

  assign out_ch.valid     = out_valid;
  assign out_ch.out_pixel = out_pixel;
  assign out_ch.overflow  = out_ovf;

  // channel datapath: v*255 formed as (v << 8) - v, then one quotient bit a step
  always_comb begin
    result = '0;
    for (int unsigned c = 0; c < NC; c++) begin
      imax[c]    = pfc_pkg::field_max(cfg.in_maxes, c);
      pix_sh[c]  = head.pixel >> pfc_pkg::field_shift(cfg.in_shifts, c);
      scaled[c]  = {pix_sh[c][MW-1:0] & imax[c], {QW{1'b0}}}
                   - {{QW{1'b0}}, pix_sh[c][MW-1:0] & imax[c]};
      shifted[c] = {rem[c], num_lo[c][QW-1]};
      ge[c]      = shifted[c] >= {1'b0, dvs[c]};
      diff[c]    = shifted[c] - {1'b0, dvs[c]};
      // zero max scales to zero
      masked[c]  = (dvs[c] == '0) ? '0
                   : ({{(MW-QW){1'b0}}, quo[c]} & pfc_pkg::field_max(cfg.out_maxes, c));
      result     = result
                   | (PW'(masked[c]) << pfc_pkg::field_shift(cfg.out_shifts, c));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfc_pkg::CV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      pfc_pkg::CV_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = pfc_pkg::CV_DIV;
        end
      end
      pfc_pkg::CV_DIV: begin
        if (step == STEP_W'(QW - 1)) begin
          state_next = pfc_pkg::CV_DONE;
        end
      end
      pfc_pkg::CV_DONE: begin
        if (!out_valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = pfc_pkg::CV_IDLE;
        end
      end
      default: state_next = pfc_pkg::CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      step <= '0;
      ovf  <= head.overflow;
      for (int unsigned c = 0; c < NC; c++) begin
        rem[c]    <= scaled[c][pfc_pkg::SCALED_W-1:QW];
        num_lo[c] <= scaled[c][QW-1:0];
        quo[c]    <= '0;
        dvs[c]    <= imax[c];
      end
    end else if (state == pfc_pkg::CV_DIV) begin
      step <= step + 1'b1;
      for (int unsigned c = 0; c < NC; c++) begin
        rem[c]    <= ge[c] ? diff[c][MW-1:0] : shifted[c][MW-1:0];
        num_lo[c] <= {num_lo[c][QW-2:0], 1'b0};
        quo[c]    <= {quo[c][QW-2:0], ge[c]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel <= ovf ? '0 : result;
      out_ovf   <= ovf;
    end
  end

endmodule

// ----- src/rfb_pixel_format_converter.sv -----
// ----------------------------------------------------------------------------
// rfb_pixel_format_converter
// Converts a byte stream of framebuffer pixels into the output pixel format.
// ----------------------------------------------------------------------------
// Bytes enter on in_ch one per cycle while the pixel queue has room and are
// gathered big-endian into pixels of 1, 2, 3 or 4 bytes; each finished pixel
// (or a buffer that ends mid-pixel, reported as 0 with overflow set) goes into
// a short queue. The converter behind the queue takes one pixel at a time and
// works through it in order: a load, 8 steps of the per-channel restoring
// dividers that compute value*255/max for red, green and blue in parallel, and
// a pack of the channels into the output register once that register is free.
// It pops no new pixel before the last one is packed; bytes of the next pixels
// keep flowing in meanwhile up to the queue depth. The output register holds a
// finished pixel until out_ch takes it while the next pixel is converted.
// Registers are written on cfg_ch (index as listed: bpp, depth, zrle, in shifts,
// in maxes, out shifts, out maxes); write them only while no transaction is
// in flight. A change of pixel size applies at once, even mid-pixel.
// ----------------------------------------------------------------------------
module rfb_pixel_format_converter #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic         clk,
  input logic         rst,
  pfc_in_if.sink      in_ch,
  pfc_out_if.source   out_ch,
  pfc_cfg_if.sink     cfg_ch
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pfc_pkg::cfg_t     cfg;
  pfc_pkg::q_wr_t    q_wr;
  pfc_pkg::q_item_t  q_head;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [CNT_W-1:0]  q_count;

  // register file
  pfc_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // front end: byte gathering and end-of-buffer detection
  pfc_gather u_gather (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  // decouples the gatherer from the dividers
  pfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty),
    .count (q_count)
  );

  // back end: channel scaling and output packing
  pfc_convert u_convert (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .head    (q_head),
    .q_empty (q_empty),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  // an overflow transaction always carries a zero pixel
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.overflow |-> out_ch.out_pixel == '0)
    else $error("overflow transaction with nonzero pixel");

  // no byte taken while the queue cannot hold a pixel
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !in_ch.ready)
    else $error("input accepted with queue full");

  // queue occupancy stays in range
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");
`endif

endmodule
